[src/link_frame_receiver_defines.svh]
// Assertion macros for the link frame receiver.
`ifndef LINK_FRAME_RECEIVER_DEFINES_SVH
`define LINK_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clock, off during reset
`define LFR_ASSERT_COMB(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, off during reset
`define LFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LFR_ASSERT_COMB(label, ante, cons, msg)
`define LFR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[src/lfr_pkg.sv]
// Shared types and constants of the link frame receiver.
`default_nettype none

package lfr_pkg;

   // Framing bytes
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLAG  = 8'h5E;

   // Control field codes
   localparam logic [7:0] CTL_SET  = 8'h03;
   localparam logic [7:0] CTL_DISC = 8'h0B;
   localparam logic [7:0] CTL_UA   = 8'h07;
   localparam logic [7:0] CTL_SEQ1 = 8'h40;
   localparam logic [7:0] CTL_SEQ0 = 8'h00;

   // Register reset values and sizes
   localparam logic [7:0]  STATION_ADDRESS_RESET = 8'h03;
   localparam int          MAX_PAYLOAD_WIDTH     = 12;
   localparam int          COUNT_WIDTH           = MAX_PAYLOAD_WIDTH + 1;
   localparam logic [MAX_PAYLOAD_WIDTH-1:0] MAX_PAYLOAD_RESET = 12'd494;

   // Register indexes on the csr port
   localparam logic CSR_STATION_ADDRESS = 1'b0;
   localparam logic CSR_MAX_PAYLOAD     = 1'b1;

   // Receive phases
   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_ADDR   = 3'd1,
      PH_CTRL   = 3'd2,
      PH_HCHK   = 3'd3,
      PH_SUPEND = 3'd4,
      PH_DATA   = 3'd5
   } phase_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_GOOD    = 3'd1,
      KIND_REJECT  = 3'd2,
      KIND_SET     = 3'd3,
      KIND_DISC    = 3'd4,
      KIND_UA      = 3'd5
   } kind_type;

   function automatic logic is_supervision(input logic [7:0] c);
      return (c == CTL_SET) || (c == CTL_DISC) || (c == CTL_UA);
   endfunction

endpackage

`default_nettype wire

[src/link_frame_receiver.sv]
// Link frame receiver: byte-stuffed HDLC-like frame parser with destuffing.
//
//   channel  dir  payload                                   handshake
//   req      in   tdata[7:0] rx_byte                        tvalid/tready
//   rsp      out  tuser[2:0] frame_kind,                    tvalid/tready
//                 tdata[7:0] payload_byte, tdata[8] frame_seq
//   csr      in   index 0 station_address, 1 max_payload    wen, no wait
//
// One byte per cycle; each transaction is parsed in the cycle it is accepted
// and its result, if any, lands in the rsp register on the same edge.
// A byte is taken while the rsp register is empty or being drained, so the
// throughput is one byte per cycle as long as rsp_tready stays high.
// Reset (synchronous, active high) returns to flag hunting with sequence 0
// and restores the register defaults; there is no clearing pass.
`default_nettype none

module link_frame_receiver #(
   parameter int MaxPayloadWidth = lfr_pkg::MAX_PAYLOAD_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // rx_byte [7:0]
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,
   // payload_byte [7:0], frame_seq [8], zero [15:9]
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [15:0]                     rsp_tdata,
   // frame_kind [2:0]
   output logic [2:0]                      rsp_tuser,
   input  wire logic                       csr_wen,
   input  wire logic                       csr_index,
   input  wire logic [MaxPayloadWidth-1:0] csr_wdata
);
   import lfr_pkg::*;

   localparam int CountWidth = MaxPayloadWidth + 1;
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   // Configuration registers
   logic [7:0]                 station_address_ff;
   logic [MaxPayloadWidth-1:0] max_payload_ff;

   // Parser state
   phase_type             phase_ff, phase_in;
   logic                  seq_ff, seq_in;
   logic [7:0]            ctl_ff, ctl_in;
   logic                  esc_ff, esc_in;
   logic [7:0]            held_ff, held_in;
   logic [7:0]            chk_ff, chk_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;

   // Result register
   logic       out_valid_ff;
   kind_type   out_kind_ff, out_kind_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_seq_ff, out_seq_in;
   logic       emit;

   // Decode of the current byte
   logic                  accept;
   logic                  is_flag;
   logic [7:0]            dctl;
   logic                  ctl_ok;
   logic                  hdr_ok;
   logic                  data_step;
   logic [7:0]            data_val;
   logic                  pay_emit;
   logic                  frame_good;
   logic [CountWidth-1:0] max_ext;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_flag    = (req_tdata == FLAG_BYTE);
   assign dctl       = seq_ff ? CTL_SEQ1 : CTL_SEQ0;
   assign ctl_ok     = is_supervision(req_tdata) || (req_tdata == dctl);
   assign hdr_ok     = (req_tdata == (station_address_ff ^ ctl_ff));
   assign max_ext    = {1'b0, max_payload_ff};

   // A destuffed data byte: plain byte, or the one after an escape
   assign data_step  = (phase_ff == PH_DATA) && !is_flag && (esc_ff || req_tdata != ESC_BYTE);
   assign data_val   = !esc_ff ? req_tdata : ((req_tdata == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE);
   assign pay_emit   = data_step && (cnt_ff != '0) && (cnt_ff <= max_ext);
   assign frame_good = !esc_ff && (cnt_ff >= CountWidth'(2))
                       && ((cnt_ff - CountWidth'(1)) <= max_ext) && (held_ff == chk_ff);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (is_flag) phase_in = PH_ADDR;
            end
            PH_ADDR: begin
               if (req_tdata == station_address_ff) phase_in = PH_CTRL;
               else phase_in = is_flag ? PH_ADDR : PH_HUNT;
            end
            PH_CTRL: begin
               if (ctl_ok) phase_in = PH_HCHK;
               else phase_in = is_flag ? PH_ADDR : PH_HUNT;
            end
            PH_HCHK: begin
               if (hdr_ok) phase_in = is_supervision(ctl_ff) ? PH_SUPEND : PH_DATA;
               else phase_in = is_flag ? PH_ADDR : PH_HUNT;
            end
            PH_SUPEND: begin
               phase_in = is_flag ? PH_ADDR : PH_HUNT;
            end
            PH_DATA: begin
               if (is_flag) phase_in = PH_ADDR;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // Frame data state and result
   always_comb begin
      seq_in      = seq_ff;
      ctl_in      = ctl_ff;
      esc_in      = esc_ff;
      held_in     = held_ff;
      chk_in      = chk_ff;
      cnt_in      = cnt_ff;
      emit        = 1'b0;
      out_kind_in = KIND_PAYLOAD;
      out_byte_in = 8'h00;
      out_seq_in  = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_CTRL: begin
               if (ctl_ok) ctl_in = req_tdata;
            end
            PH_HCHK: begin
               // Data header: start a fresh payload
               if (hdr_ok && !is_supervision(ctl_ff)) begin
                  esc_in  = 1'b0;
                  held_in = 8'h00;
                  chk_in  = 8'h00;
                  cnt_in  = '0;
               end
            end
            PH_SUPEND: begin
               if (is_flag) begin
                  emit = 1'b1;
                  if (ctl_ff == CTL_SET) out_kind_in = KIND_SET;
                  else if (ctl_ff == CTL_DISC) out_kind_in = KIND_DISC;
                  else out_kind_in = KIND_UA;
               end
            end
            PH_DATA: begin
               if (is_flag) begin
                  // Closing flag; aborted if it follows an escape
                  emit        = 1'b1;
                  out_kind_in = frame_good ? KIND_GOOD : KIND_REJECT;
                  out_seq_in  = seq_ff;
                  esc_in      = 1'b0;
                  if (frame_good) seq_in = !seq_ff;
               end else if (data_step) begin
                  esc_in  = 1'b0;
                  held_in = data_val;
                  if (cnt_ff != CountMax) cnt_in = cnt_ff + CountWidth'(1);
                  if (pay_emit) begin
                     emit        = 1'b1;
                     out_kind_in = KIND_PAYLOAD;
                     out_byte_in = held_ff;
                     out_seq_in  = seq_ff;
                     chk_in      = chk_ff ^ held_ff;
                  end
               end else begin
                  esc_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= STATION_ADDRESS_RESET;
         max_payload_ff     <= MaxPayloadWidth'(MAX_PAYLOAD_RESET);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_STATION_ADDRESS: station_address_ff <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD:     max_payload_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         seq_ff   <= 1'b0;
         ctl_ff   <= 8'h00;
         esc_ff   <= 1'b0;
         held_ff  <= 8'h00;
         chk_ff   <= 8'h00;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         ctl_ff   <= ctl_in;
         esc_ff   <= esc_in;
         held_ff  <= held_in;
         chk_ff   <= chk_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Result register: loads on emit, drains on rsp_tready
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff <= out_kind_in;
         out_byte_ff <= out_byte_in;
         out_seq_ff  <= out_seq_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {7'b0, out_seq_ff, out_byte_ff};

`include "link_frame_receiver_defines.svh"

   `LFR_ASSERT_COMB(a_pay_seq, out_valid_ff && out_kind_ff == KIND_PAYLOAD, out_seq_ff == seq_ff, "payload sequence bit differs from expected")
   `LFR_ASSERT_COMB(a_pay_cnt, out_valid_ff && out_kind_ff == KIND_PAYLOAD, cnt_ff >= CountWidth'(2), "payload byte out with short count")
   `LFR_ASSERT_COMB(a_close_addr, out_valid_ff && out_kind_ff != KIND_PAYLOAD, phase_ff == PH_ADDR, "frame report without address phase")
   `LFR_ASSERT_COMB(a_esc_data, esc_ff, phase_ff == PH_DATA, "escape pending outside data phase")
   `LFR_ASSERT_NEXT(a_flag_close, accept && phase_ff == PH_DATA && is_flag, out_valid_ff && phase_ff == PH_ADDR, "closing flag gave no report")

endmodule

`default_nettype wire
